/* rtl/mtbl_pkg.sv */
// package for the multi token bucket limiter
// holds command, status and sequencer state codes; no dependencies

package mtbl_pkg;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_ALLOC    = 3'd1,
      CMD_FETCH    = 3'd2,
      CMD_RETURN   = 3'd3,
      CMD_FREE     = 3'd4,
      CMD_FREE_ALL = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_BAD   = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_WALK,
      SEQ_DONE
   } seq_state_type;

   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;

endpackage

/* rtl/mtbl_cell.sv */
// one bucket cell of the rotating bucket ring
// depends on no other file; hands its bucket to the next cell on shift

module mtbl_cell #(
   parameter int TOKEN_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift,
   input  logic                  live_nxt,
   input  logic [TOKEN_BITS-1:0] tok_nxt,
   input  logic [TOKEN_BITS-1:0] rate_nxt,
   input  logic [TOKEN_BITS-1:0] lim_nxt,
   output logic                  live_cur,
   output logic [TOKEN_BITS-1:0] tok_cur,
   output logic [TOKEN_BITS-1:0] rate_cur,
   output logic [TOKEN_BITS-1:0] lim_cur
);

   logic                  live_ff;
   logic [TOKEN_BITS-1:0] tok_ff;
   logic [TOKEN_BITS-1:0] rate_ff;
   logic [TOKEN_BITS-1:0] lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else if (shift) begin
         live_ff <= live_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         tok_ff  <= tok_nxt;
         rate_ff <= rate_nxt;
         lim_ff  <= lim_nxt;
      end
   end

   assign live_cur = live_ff;
   assign tok_cur  = tok_ff;
   assign rate_cur = rate_ff;
   assign lim_cur  = lim_ff;

endmodule

/* rtl/mtbl_ctrl.sv */
// command sequencer and head-of-ring update logic
// uses mtbl_pkg; walks the bucket ring once per command and builds the result beat

module mtbl_ctrl import mtbl_pkg::*; #(
   parameter int NUM_BUCKETS = 16,
   parameter int TOKEN_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  shift,
   input  logic                  head_live,
   input  logic [TOKEN_BITS-1:0] head_tok,
   input  logic [TOKEN_BITS-1:0] head_rate,
   input  logic [TOKEN_BITS-1:0] head_lim,
   output logic                  tail_live,
   output logic [TOKEN_BITS-1:0] tail_tok,
   output logic [TOKEN_BITS-1:0] tail_rate,
   output logic [TOKEN_BITS-1:0] tail_lim
);

   localparam int K_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int EXT_W = TOKEN_BITS + 16;

   seq_state_type         state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [3:0]            id_ff, id_in;
   logic [TOKEN_BITS-1:0] amt_ff, amt_in;
   logic [TOKEN_BITS-1:0] rate_ff, rate_in;
   logic [TOKEN_BITS-1:0] lim_ff, lim_in;
   logic [K_W-1:0]        k_ff, k_in;
   logic                  found_ff, found_in;
   status_type            status_ff, status_in;
   logic [3:0]            given_ff, given_in;
   logic [TOKEN_BITS-1:0] granted_ff, granted_in;

   logic [EXT_W-1:0]      amt_ext, rate_ext, lim_ext, granted_ext;
   logic [K_W+3:0]        k_ext, id_ext;
   logic                  match;
   logic [TOKEN_BITS-1:0] addend, clamped, take;
   logic [TOKEN_BITS:0]   sum;
   status_type            start_status;

   // input fields cut or widened to the token width
   assign amt_ext  = {{TOKEN_BITS{1'b0}}, req_tdata[19:4]};
   assign rate_ext = {{TOKEN_BITS{1'b0}}, req_tdata[35:20]};
   assign lim_ext  = {{TOKEN_BITS{1'b0}}, req_tdata[51:36]};

   assign k_ext  = {4'b0, k_ff};
   assign id_ext = {{K_W{1'b0}}, id_ff};
   assign match  = (k_ext == id_ext);

   // saturating add shared by tick and return
   assign addend  = (cmd_ff == CMD_TICK) ? head_rate : amt_ff;
   assign sum     = {1'b0, head_tok} + {1'b0, addend};
   assign clamped = (sum > {1'b0, head_lim}) ? head_lim : sum[TOKEN_BITS-1:0];
   assign take    = (amt_ff < head_tok) ? amt_ff : head_tok;

   always_comb begin
      case (cmd_type'(req_tuser))
         CMD_TICK, CMD_FREE_ALL: start_status = ST_OK;
         CMD_ALLOC:              start_status = ST_FULL;
         default:                start_status = ST_BAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      id_ff      <= id_in;
      amt_ff     <= amt_in;
      rate_ff    <= rate_in;
      lim_ff     <= lim_in;
      k_ff       <= k_in;
      found_ff   <= found_in;
      status_ff  <= status_in;
      given_ff   <= given_in;
      granted_ff <= granted_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      id_in      = id_ff;
      amt_in     = amt_ff;
      rate_in    = rate_ff;
      lim_in     = lim_ff;
      k_in       = k_ff;
      found_in   = found_ff;
      status_in  = status_ff;
      given_in   = given_ff;
      granted_in = granted_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      shift      = 1'b0;
      tail_live  = head_live;
      tail_tok   = head_tok;
      tail_rate  = head_rate;
      tail_lim   = head_lim;

      case (state_ff)
         SEQ_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in     = cmd_type'(req_tuser);
               id_in      = req_tdata[3:0];
               amt_in     = amt_ext[TOKEN_BITS-1:0];
               rate_in    = rate_ext[TOKEN_BITS-1:0];
               lim_in     = lim_ext[TOKEN_BITS-1:0];
               k_in       = '0;
               found_in   = 1'b0;
               status_in  = start_status;
               given_in   = 4'd0;
               granted_in = '0;
               state_in   = SEQ_WALK;
            end
         end
         SEQ_WALK: begin
            shift = 1'b1;
            case (cmd_ff)
               CMD_TICK: begin
                  if (head_live) begin
                     tail_tok = clamped;
                  end
               end
               CMD_ALLOC: begin
                  if (!head_live && !found_ff) begin
                     tail_live = 1'b1;
                     tail_tok  = '0;
                     tail_rate = rate_ff;
                     tail_lim  = lim_ff;
                     found_in  = 1'b1;
                     status_in = ST_OK;
                     given_in  = k_ext[3:0];
                  end
               end
               CMD_FETCH: begin
                  if (match && head_live) begin
                     if (head_tok == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        status_in  = ST_OK;
                        granted_in = take;
                        tail_tok   = head_tok - take;
                     end
                  end
               end
               CMD_RETURN: begin
                  if (match && head_live) begin
                     status_in = ST_OK;
                     tail_tok  = clamped;
                  end
               end
               CMD_FREE: begin
                  if (match && head_live) begin
                     status_in = ST_OK;
                     tail_live = 1'b0;
                  end
               end
               CMD_FREE_ALL: begin
                  tail_live = 1'b0;
               end
               default: begin
               end
            endcase
            if (k_ff == K_W'(NUM_BUCKETS - 1)) begin
               state_in = SEQ_DONE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         SEQ_DONE: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign granted_ext = {16'b0, granted_ff};
   assign rsp_tdata   = {4'b0, granted_ext[15:0], given_ff};
   assign rsp_tuser   = status_ff;

endmodule

/* rtl/multi_token_bucket_limiter_top.sv */
// Token bucket rate limiter with NUM_BUCKETS buckets held in a ring of cells that
// rotates one place per cycle while a command walks it; every command walks the
// whole ring once, updating each bucket as it passes the head. A command is taken,
// the ring steps through every bucket, and the result beat is held until accepted.
// One command is in flight at a time and each gives exactly one result beat.
// depends on mtbl_pkg, mtbl_cell and mtbl_ctrl

module multi_token_bucket_limiter_top import mtbl_pkg::*; #(
   parameter int NUM_BUCKETS = 16,
   parameter int TOKEN_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // bucket_id[3:0], amount[19:4], rate[35:20], limit[51:36], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd[2:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // slot_given[3:0], granted[19:4], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   logic                  shift;
   logic                  live_w [NUM_BUCKETS];
   logic [TOKEN_BITS-1:0] tok_w  [NUM_BUCKETS];
   logic [TOKEN_BITS-1:0] rate_w [NUM_BUCKETS];
   logic [TOKEN_BITS-1:0] lim_w  [NUM_BUCKETS];
   logic                  tail_live;
   logic [TOKEN_BITS-1:0] tail_tok, tail_rate, tail_lim;

   mtbl_ctrl #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .TOKEN_BITS  (TOKEN_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .shift      (shift),
      .head_live  (live_w[0]),
      .head_tok   (tok_w[0]),
      .head_rate  (rate_w[0]),
      .head_lim   (lim_w[0]),
      .tail_live  (tail_live),
      .tail_tok   (tail_tok),
      .tail_rate  (tail_rate),
      .tail_lim   (tail_lim)
   );

   // cell i takes from cell i+1; the last cell takes the updated head bucket
   for (genvar i = 0; i < NUM_BUCKETS; i++) begin : g_cell
      if (i == NUM_BUCKETS - 1) begin : g_tail
         mtbl_cell #(
            .TOKEN_BITS (TOKEN_BITS)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (shift),
            .live_nxt (tail_live),
            .tok_nxt  (tail_tok),
            .rate_nxt (tail_rate),
            .lim_nxt  (tail_lim),
            .live_cur (live_w[i]),
            .tok_cur  (tok_w[i]),
            .rate_cur (rate_w[i]),
            .lim_cur  (lim_w[i])
         );
      end else begin : g_body
         mtbl_cell #(
            .TOKEN_BITS (TOKEN_BITS)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (shift),
            .live_nxt (live_w[i+1]),
            .tok_nxt  (tok_w[i+1]),
            .rate_nxt (rate_w[i+1]),
            .lim_nxt  (lim_w[i+1]),
            .live_cur (live_w[i]),
            .tok_cur  (tok_w[i]),
            .rate_cur (rate_w[i]),
            .lim_cur  (lim_w[i])
         );
      end
   end

endmodule

/* dv/tb.sv */
// testbench for multi_token_bucket_limiter_top: a directed table walk, then mixed random
// command streams, all checked beat by beat against an in-bench bucket table model
// depends on mtbl_pkg and the rtl of the limiter
`timescale 1ns / 1ps

module tb import mtbl_pkg::*; ();

   localparam int NUM_BUCKETS = 16;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam logic [2:0] CMD_RSVD_A = 3'd6;
   localparam logic [2:0] CMD_RSVD_B = 3'd7;

   typedef struct packed {
      status_type  status;
      logic [3:0]  slot;
      logic [15:0] granted;
   } grant_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   logic        bucket_live [NUM_BUCKETS];
   logic [15:0] bucket_tokens [NUM_BUCKETS];
   logic [15:0] bucket_rate [NUM_BUCKETS];
   logic [15:0] bucket_cap [NUM_BUCKETS];

   grant_result_type pending_results[$];
   int unsigned   items_sent;
   int unsigned   results_checked;
   int unsigned   error_count;
   int unsigned   status_seen [4];
   bit            send_idle_on;
   bit            sink_stall_on;
   int            long_hold;

   multi_token_bucket_limiter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [15:0] add_clamped(input logic [15:0] base,
         input logic [15:0] extra, input logic [15:0] cap);
      logic [16:0] sum;
      sum = base + extra;
      return (sum > {1'b0, cap}) ? cap : sum[15:0];
   endfunction

   // updates the bucket table and returns the answer for one command
   function automatic grant_result_type predict_limiter(input logic [2:0] op,
         input logic [3:0] id, input logic [15:0] amt, input logic [15:0] rt,
         input logic [15:0] lm);
      grant_result_type res;
      bit            found;
      res = '{status: ST_OK, slot: 4'd0, granted: 16'd0};
      found = 1'b0;
      case (op)
         CMD_TICK: begin
            for (int i = 0; i < NUM_BUCKETS; i++)
               if (bucket_live[i])
                  bucket_tokens[i] = add_clamped(bucket_tokens[i], bucket_rate[i],
                                                 bucket_cap[i]);
         end
         CMD_ALLOC: begin
            res.status = ST_FULL;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
               if (!found && !bucket_live[i]) begin
                  found            = 1'b1;
                  bucket_tokens[i] = 16'd0;
                  bucket_rate[i]   = rt;
                  bucket_cap[i]    = lm;
                  bucket_live[i]   = 1'b1;
                  res.slot         = i[3:0];
                  res.status       = ST_OK;
               end
            end
         end
         CMD_FETCH: begin
            if (!bucket_live[id])
               res.status = ST_BAD;
            else if (bucket_tokens[id] == 16'd0)
               res.status = ST_EMPTY;
            else begin
               res.granted = (amt < bucket_tokens[id]) ? amt : bucket_tokens[id];
               bucket_tokens[id] = bucket_tokens[id] - res.granted;
            end
         end
         CMD_RETURN: begin
            if (!bucket_live[id])
               res.status = ST_BAD;
            else
               bucket_tokens[id] = add_clamped(bucket_tokens[id], amt, bucket_cap[id]);
         end
         CMD_FREE: begin
            if (!bucket_live[id])
               res.status = ST_BAD;
            else
               bucket_live[id] = 1'b0;
         end
         CMD_FREE_ALL: begin
            for (int i = 0; i < NUM_BUCKETS; i++)
               bucket_live[i] = 1'b0;
         end
         default: res.status = ST_BAD;
      endcase
      status_seen[res.status]++;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
         input int unsigned want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch at result %0d: %s got 0x%0h, want 0x%0h",
                  results_checked, what, got, want);
   endtask

   task automatic send_cmd(input logic [2:0] op, input logic [3:0] id,
         input logic [15:0] amt, input logic [15:0] rt, input logic [15:0] lm);
      int gap;
      gap = send_idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0000, lm, rt, amt, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_limiter(op, id, amt, rt, lm));
      items_sent++;
   endtask

   // sender goes quiet until every expected beat has come back
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic logic [15:0] rand_tokens();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3, 4: return 16'($urandom_range(0, 31));
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly a live slot, sometimes any slot
   function automatic logic [3:0] pick_slot();
      int live_ids[$];
      for (int i = 0; i < NUM_BUCKETS; i++)
         if (bucket_live[i]) live_ids.push_back(i);
      if (live_ids.size() == 0 || $urandom_range(0, 4) == 0)
         return 4'($urandom_range(0, 15));
      return 4'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
   endfunction

   // receiver: ready with random stalls, plus a long hold-off on request
   initial begin : sink
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            stall_left = sink_stall_on ? $urandom_range(0, 7) : 0;
         if (reset)
            rsp_tready <= 1'b0;
         else if (long_hold > 0) begin
            long_hold--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= 1'b1;
      end
   end

   initial begin : result_check
      grant_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0)
               report_mismatch("unexpected beat, status", rsp_tuser, 0);
            else begin
               want = pending_results.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", rsp_tuser, want.status);
               if (rsp_tdata[3:0] !== want.slot)
                  report_mismatch("slot_given", rsp_tdata[3:0], want.slot);
               if (rsp_tdata[19:4] !== want.granted)
                  report_mismatch("granted", rsp_tdata[19:4], want.granted);
            end
            results_checked++;
         end
      end
   end

   task automatic test_empty_table();
      send_cmd(CMD_FETCH, 4'd15, 16'd1, 16'd0, 16'd0);
      send_cmd(CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0);
   endtask

   task automatic test_fill_table();
      send_cmd(CMD_ALLOC, 4'd0, 16'd0, 16'hFFFF, 16'hFFFF);
      send_cmd(CMD_ALLOC, 4'd0, 16'd0, 16'h0000, 16'h0000);
      send_cmd(CMD_ALLOC, 4'd0, 16'd0, 16'd3, 16'd10);
      for (int i = 3; i < NUM_BUCKETS; i++)
         send_cmd(CMD_ALLOC, 4'($urandom), 16'($urandom), rand_tokens(), rand_tokens());
      send_cmd(CMD_ALLOC, 4'd0, 16'd0, 16'd7, 16'd7);
   endtask

   task automatic test_token_edges();
      send_cmd(CMD_FETCH, 4'd0, 16'd5, 16'd0, 16'd0);
      send_cmd(CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0);
      send_cmd(CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0);
      send_cmd(CMD_FETCH, 4'd0, 16'd0, 16'd0, 16'd0);
      send_cmd(CMD_FETCH, 4'd0, 16'hFFFF, 16'd0, 16'd0);
      send_cmd(CMD_RETURN, 4'd2, 16'hFFFF, 16'd0, 16'd0);
      send_cmd(CMD_FETCH, 4'd2, 16'hFFFF, 16'd0, 16'd0);
   endtask

   task automatic test_release_and_reserved();
      send_cmd(CMD_FREE, 4'd1, 16'd0, 16'd0, 16'd0);
      send_cmd(CMD_RETURN, 4'd1, 16'd9, 16'd0, 16'd0);
      send_cmd(CMD_RSVD_A, 4'd2, 16'($urandom), 16'($urandom), 16'($urandom));
      send_cmd(CMD_RSVD_B, 4'd2, 16'($urandom), 16'($urandom), 16'($urandom));
      send_cmd(CMD_FREE_ALL, 4'd0, 16'd0, 16'd0, 16'd0);
      send_cmd(CMD_FETCH, 4'd2, 16'd1, 16'd0, 16'd0);
   endtask

   task automatic send_random_cmd(input int alloc_pct);
      logic [2:0] op;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct)
         op = CMD_ALLOC;
      else begin
         pick = $urandom_range(0, 99);
         if (pick < 20)      op = CMD_TICK;
         else if (pick < 55) op = CMD_FETCH;
         else if (pick < 78) op = CMD_RETURN;
         else if (pick < 93) op = CMD_FREE;
         else if (pick < 97) op = CMD_FREE_ALL;
         else                op = pick[0] ? CMD_RSVD_A : CMD_RSVD_B;
      end
      send_cmd(op, pick_slot(), rand_tokens(), rand_tokens(), rand_tokens());
   endtask

   task automatic test_backpressure();
      @(negedge clock);
      long_hold = LONG_HOLD_CYCLES;
      @(posedge clock);
      send_idle_on = 1'b0;
      for (int n = 0; n < 8; n++)
         send_random_cmd(25);
   endtask

   task automatic test_random_traffic(input int count, input int alloc_pct);
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            send_idle_on  = ($urandom_range(0, 3) != 0);
            sink_stall_on = ($urandom_range(0, 3) != 0);
         end
         send_random_cmd(alloc_pct);
      end
   endtask

   task automatic test_drain_pause();
      wait_results_drained();
      for (int n = 0; n < 10; n++)
         send_random_cmd(30);
   endtask

   initial begin
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= '0;
      items_sent      = 0;
      results_checked = 0;
      error_count     = 0;
      long_hold       = 0;
      send_idle_on    = 1'b1;
      sink_stall_on   = 1'b1;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
         bucket_live[i]   = 1'b0;
         bucket_tokens[i] = 16'd0;
         bucket_rate[i]   = 16'd0;
         bucket_cap[i]    = 16'd0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_fill_table();
      test_token_edges();
      test_release_and_reserved();
      test_backpressure();
      test_random_traffic(300, 25);
      test_drain_pause();
      test_random_traffic(150, 60);
      test_random_traffic(240, 25);

      wait_results_drained();
      repeat (NUM_BUCKETS + 8) @(posedge clock);
      $display("covered %0d commands and %0d checked beats", items_sent, results_checked);
      $display("answers: %0d ok, %0d bad slot, %0d empty, %0d table full",
               status_seen[ST_OK], status_seen[ST_BAD], status_seen[ST_EMPTY],
               status_seen[ST_FULL]);
      if (error_count == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* multi_token_bucket_limiter_top.f */
rtl/mtbl_pkg.sv
rtl/mtbl_cell.sv
rtl/mtbl_ctrl.sv
rtl/multi_token_bucket_limiter_top.sv
dv/tb.sv
